// File: sv/igcd_pkg.sv
package igcd_pkg;

	localparam int VALUE_WIDTH  = 31;
	localparam int MODE_WIDTH   = 3;
	localparam int SHIFT_WIDTH  = $clog2(VALUE_WIDTH);

	localparam int IN_FIELDS_W  = MODE_WIDTH + 2 * VALUE_WIDTH;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = VALUE_WIDTH + 1;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [MODE_WIDTH-1:0] {
		MODE_MAX       = 3'd0,
		MODE_MIN       = 3'd1,
		MODE_GCD       = 3'd2,
		MODE_DIV_TEST  = 3'd3,
		MODE_DIVIDEND  = 3'd4,
		MODE_DIVISOR   = 3'd5
	} mode_t;

	// one classified item as it sits in the queue
	typedef struct packed {
		logic [MODE_WIDTH-1:0]  mode;
		logic [VALUE_WIDTH-1:0] big;
		logic [VALUE_WIDTH-1:0] small_val;
	} item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} back_state_t;

endpackage

// File: sv/integer_pair_gcd_unit_core.sv
// Channel   Dir  Fields in tdata, lowest bit first
// --------  ---  ----------------------------------------------------------
// s_*       in   mode[2:0], first_value[33:3], second_value[64:34], pad to 72
// m_*       out  result_value[30:0], divisible_flag[31]
//
// Flow: the front orders the pair and queues it in the same cycle as the
//   transfer. The back pops one item, runs a binary gcd loop (one shift or one
//   subtract-and-shift per cycle, at most 2*VALUE_WIDTH-2 steps, none when
//   either value is zero), then loads the result once the output is free.
//   Each item passes pop, the loop with its final compare, and load; a zero
//   operand skips the loop and its compare.
// Reset: arst_n clears the queue pointers, back state and output valid.
// Stalls: s_tready stays high until two items wait in the queue; a held
//   result stalls the back end, and the input only once the queue fills.
module integer_pair_gcd_unit_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [igcd_pkg::IN_DATA_W-1:0]  s_tdata,   // mode, first_value, second_value
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [igcd_pkg::OUT_DATA_W-1:0] m_tdata    // result_value, divisible_flag
);
	import igcd_pkg::*;

	logic  q_push;
	logic  q_pop;
	logic  q_full;
	logic  q_empty;
	item_t push_item;
	item_t head_item;

	// front: classify the pair into larger/smaller
	igcd_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	// decoupling queue between front and back
	igcd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.head_item (head_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	// back: iterative gcd, divisibility and result register
	igcd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (head_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// File: sv/igcd_front.sv
module igcd_front (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [igcd_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic                          q_full,
	output logic                          q_push,
	output igcd_pkg::item_t               q_item
);
	import igcd_pkg::*;

	logic [VALUE_WIDTH-1:0] first_v;
	logic [VALUE_WIDTH-1:0] second_v;
	logic                   first_lt;

	assign first_v  = s_tdata[MODE_WIDTH +: VALUE_WIDTH];
	assign second_v = s_tdata[MODE_WIDTH + VALUE_WIDTH +: VALUE_WIDTH];
	assign first_lt = first_v < second_v;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// order the pair so the back end receives larger and smaller already sorted
	always_comb begin
		q_item.mode      = s_tdata[MODE_WIDTH-1:0];
		q_item.big       = first_lt ? second_v : first_v;
		q_item.small_val = first_lt ? first_v : second_v;
	end

endmodule

// File: sv/igcd_queue.sv
module igcd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  igcd_pkg::item_t push_item,
	input  logic            pop,
	output igcd_pkg::item_t head_item,
	output logic            full,
	output logic            empty
);
	import igcd_pkg::*;

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty     = count_q == '0;
	assign head_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: sv/igcd_back.sv
module igcd_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  igcd_pkg::item_t                q_head,
	output logic                           q_pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [igcd_pkg::OUT_DATA_W-1:0] m_tdata
);
	import igcd_pkg::*;

	back_state_t            state_q;
	back_state_t            state_nxt;
	logic [MODE_WIDTH-1:0]  mode_q;
	logic [VALUE_WIDTH-1:0] big_q;
	logic [VALUE_WIDTH-1:0] small_q;
	logic [VALUE_WIDTH-1:0] a_q;
	logic [VALUE_WIDTH-1:0] b_q;
	logic [SHIFT_WIDTH-1:0] k_q;

	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_result_q;
	logic                   out_flag_q;

	logic                   out_free;
	logic                   load_out;
	logic                   a_gt_b;
	logic [VALUE_WIDTH-1:0] a_minus_b;
	logic [VALUE_WIDTH-1:0] b_minus_a;
	logic [VALUE_WIDTH-1:0] gcd_val;
	logic                   div_flag;
	logic [VALUE_WIDTH-1:0] result_val;

	assign out_free  = !out_valid_q || m_tready;
	assign a_gt_b    = a_q > b_q;
	assign a_minus_b = a_q - b_q;
	assign b_minus_a = b_q - a_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					state_nxt = (q_head.small_val == '0) ? ST_DONE : ST_RUN;
				end
			end
			ST_RUN: begin
				if (a_q == b_q) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		q_pop    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: q_pop    = !q_empty;
			ST_DONE: load_out = out_free;
			default: begin
				q_pop    = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	// result selection; gcd equals the smaller value exactly when it divides the larger
	always_comb begin
		gcd_val  = (small_q == '0) ? '0 : VALUE_WIDTH'(a_q << k_q);
		div_flag = (small_q == '0) ? (big_q != '0) : (gcd_val == small_q);
		case (mode_q)
			MODE_MAX:      result_val = big_q;
			MODE_MIN:      result_val = small_q;
			MODE_GCD:      result_val = gcd_val;
			MODE_DIV_TEST: result_val = '0;
			MODE_DIVIDEND: result_val = div_flag ? big_q : '0;
			MODE_DIVISOR:  result_val = div_flag ? small_q : '0;
			default:       result_val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// binary gcd: strip shared twos into k, strip lone twos, halve odd differences
	always_ff @(posedge clk) begin
		if (q_pop) begin
			mode_q  <= q_head.mode;
			big_q   <= q_head.big;
			small_q <= q_head.small_val;
			a_q     <= q_head.big;
			b_q     <= q_head.small_val;
			k_q     <= '0;
		end else if (state_q == ST_RUN && a_q != b_q) begin
			if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_gt_b) begin
				a_q <= a_minus_b >> 1;
			end else begin
				b_q <= b_minus_a >> 1;
			end
		end
		if (load_out) begin
			out_result_q <= result_val;
			out_flag_q   <= div_flag;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({out_flag_q, out_result_q});

endmodule

// File: sv/igcd_checker.sv
module igcd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [igcd_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [igcd_pkg::OUT_DATA_W-1:0] m_tdata
);
	import igcd_pkg::*;

	localparam int OST_W = $clog2(QUEUE_DEPTH + 3);

	logic [OST_W-1:0] open_q;
	logic             in_xfer;
	logic             out_xfer;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	// items taken in and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			open_q <= open_q + 1'b1;
		end else if (out_xfer && !in_xfer) begin
			open_q <= open_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> open_q != '0)
		else $error("result without an open item");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= OST_W'(QUEUE_DEPTH + 2))
		else $error("more items in flight than storage");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> open_q >= OST_W'(QUEUE_DEPTH))
		else $error("input stalled with queue not full");

endmodule

bind integer_pair_gcd_unit_core igcd_checker u_igcd_checker (.*);

// File: bench/tb_integer_pair_gcd_unit_core.sv
module tb_integer_pair_gcd_unit_core;

	timeunit 1ns;
	timeprecision 1ps;

	import igcd_pkg::*;

	typedef logic [VALUE_WIDTH-1:0] value_t;

	typedef struct {
		value_t result_value;
		logic   divisible_flag;
	} gcd_outcome_t;

	// codes the block has no operation for; result must be zero
	localparam logic [MODE_WIDTH-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [MODE_WIDTH-1:0] MODE_SPARE_7 = 3'd7;

	localparam value_t VALUE_MAX  = {VALUE_WIDTH{1'b1}};
	localparam int     TAIL_WAIT  = 80;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  s_tvalid   = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata    = '0;
	logic                  m_tvalid;
	logic                  m_tready   = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	gcd_outcome_t pending_outcomes[$];
	int           mismatch_count = 0;
	int           ready_hold     = 0;
	bit           idle_off       = 1'b0;

	integer_pair_gcd_unit_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("[integer_pair_gcd_unit_core] ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (idle_off || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic gcd_outcome_t predict_gcd_outcome(input logic [MODE_WIDTH-1:0] mode,
			input value_t a, input value_t b);
		gcd_outcome_t    o;
		value_t          big;
		value_t          little;
		longint unsigned x;
		longint unsigned y;
		longint unsigned t;
		logic            div;
		big    = (a < b) ? b : a;
		little = (a < b) ? a : b;
		div    = 1'b0;
		if (b != 0) begin
			if (a % b == 0)
				div = 1'b1;
		end
		if (a != 0) begin
			if (b % a == 0)
				div = 1'b1;
		end
		o.divisible_flag = div;
		o.result_value   = '0;
		case (mode)
			MODE_MAX: o.result_value = big;
			MODE_MIN: o.result_value = little;
			MODE_GCD: begin
				// zero on either side gives zero, not the other value
				if (a != 0 && b != 0) begin
					x = a;
					y = b;
					while (y != 0) begin
						t = x % y;
						x = y;
						y = t;
					end
					o.result_value = value_t'(x);
				end
			end
			MODE_DIVIDEND: o.result_value = div ? big : '0;
			MODE_DIVISOR:  o.result_value = div ? little : '0;
			default:       o.result_value = '0;
		endcase
		return o;
	endfunction

	task automatic send_pair(input logic [MODE_WIDTH-1:0] mode, input value_t a, input value_t b);
		logic [IN_DATA_W-1:0] word;
		int                   gap;
		gap  = pick_gap();
		word = '0;
		word[MODE_WIDTH-1:0]                          = mode;
		word[MODE_WIDTH +: VALUE_WIDTH]               = a;
		word[MODE_WIDTH + VALUE_WIDTH +: VALUE_WIDTH] = b;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_outcomes.push_back(predict_gcd_outcome(mode, a, b));
	endtask

	task automatic wait_results_drained();
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// operand pairs shaped to hit the interesting corners of the gcd loop
	task automatic pick_operands(output value_t a, output value_t b);
		longint unsigned g;
		longint unsigned k;
		value_t          tmp;
		case ($urandom_range(0, 9))
			0, 8, 9: begin
				a = value_t'($urandom());
				b = value_t'($urandom());
			end
			1: begin
				a = value_t'($urandom_range(0, 15));
				b = value_t'($urandom_range(0, 15));
			end
			2: begin
				a = value_t'($urandom_range(1, 46340));
				k = 64'($urandom_range(1, 46340));
				b = value_t'(a * k);
			end
			3: begin
				g = 64'($urandom_range(1, 1000));
				a = value_t'(g * 64'($urandom_range(0, 32'(64'd2147483647 / g))));
				b = value_t'(g * 64'($urandom_range(0, 32'(64'd2147483647 / g))));
			end
			4: begin
				a = '0;
				b = ($urandom_range(0, 1) == 1) ? value_t'($urandom()) : value_t'($urandom_range(0, 9));
			end
			5: begin
				a = VALUE_MAX;
				b = ($urandom_range(0, 1) == 1) ? value_t'($urandom()) : value_t'($urandom_range(0, 3));
			end
			6: begin
				a = value_t'($urandom());
				b = a;
			end
			default: begin
				a = value_t'(1) << $urandom_range(0, VALUE_WIDTH - 1);
				b = (value_t'(1) << $urandom_range(0, 12)) * value_t'($urandom_range(0, 1 << 16) | 1);
			end
		endcase
		if ($urandom_range(0, 1) == 1) begin
			tmp = a;
			a   = b;
			b   = tmp;
		end
	endtask

	function automatic logic [MODE_WIDTH-1:0] pick_mode();
		if ($urandom_range(0, 15) == 0)
			return MODE_WIDTH'($urandom_range(MODE_SPARE_6, MODE_SPARE_7));
		return MODE_WIDTH'($urandom_range(MODE_MAX, MODE_DIVISOR));
	endfunction

	task automatic send_random_pairs(input int count);
		value_t a;
		value_t b;
		repeat (count) begin
			pick_operands(a, b);
			send_pair(pick_mode(), a, b);
		end
	endtask

	task automatic test_directed_corners();
		for (int m = MODE_MAX; m <= MODE_SPARE_7; m++)
			send_pair(m[MODE_WIDTH-1:0], '0, '0);
		send_pair(MODE_GCD, '0, 31'd12345);
		send_pair(MODE_GCD, 31'd98, '0);
		send_pair(MODE_DIVIDEND, '0, 31'd77);
		send_pair(MODE_DIVISOR, 31'd77, '0);
		send_pair(MODE_GCD, VALUE_MAX, VALUE_MAX);
		send_pair(MODE_MAX, VALUE_MAX, 31'd1);
		send_pair(MODE_MIN, 31'd1, VALUE_MAX);
		send_pair(MODE_DIV_TEST, VALUE_MAX, 31'd1);
		send_pair(MODE_DIVIDEND, 31'd1, VALUE_MAX);
		send_pair(MODE_DIVISOR, 31'd6, 31'd42);
		send_pair(MODE_DIVIDEND, 31'd42, 31'd6);
		send_pair(MODE_DIV_TEST, 31'd42, 31'd5);
		send_pair(MODE_DIVISOR, 31'd9, 31'd6);
		send_pair(MODE_GCD, 31'h4000_0000, 31'h2000_0000);
		send_pair(MODE_GCD, 31'd1836311903, 31'd1134903170);
		send_pair(MODE_GCD, 31'd2147483646, 31'd1073741823);
		send_pair(MODE_MAX, 31'h2AAA_AAAA, 31'h5555_5555);
		send_pair(MODE_MIN, 31'h5555_5555, 31'h2AAA_AAAA);
		send_pair(MODE_SPARE_6, 31'd10, 31'd5);
		send_pair(MODE_SPARE_7, 31'd3, 31'd7);
	endtask

	task automatic test_random_mix();
		send_random_pairs(700);
	endtask

	task automatic test_back_to_back();
		idle_off = 1'b1;
		send_random_pairs(300);
		idle_off = 1'b0;
	endtask

	// sender holds off until the queue of expected results is empty
	task automatic test_drain_pauses();
		repeat (4) begin
			send_random_pairs(40);
			s_tvalid <= 1'b0;
			wait_results_drained();
		end
	endtask

	task automatic test_random_long();
		send_random_pairs(665);
	endtask

	always @(posedge clk) begin
		int gap;
		if (ready_hold != 0) begin
			m_tready   <= 1'b0;
			ready_hold  = ready_hold - 1;
		end else begin
			gap = pick_gap();
			if (gap == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready   <= 1'b0;
				ready_hold  = gap - 1;
			end
		end
	end

	always @(posedge clk) begin
		gcd_outcome_t want;
		value_t       got_value;
		logic         got_flag;
		if (arst_n && m_tvalid && m_tready) begin
			got_value = m_tdata[VALUE_WIDTH-1:0];
			got_flag  = m_tdata[VALUE_WIDTH];
			if (pending_outcomes.size() == 0) begin
				report_mismatch($sformatf("unexpected result value=%0d flag=%0b",
					got_value, got_flag));
			end else begin
				want = pending_outcomes.pop_front();
				if (got_value !== want.result_value)
					report_mismatch($sformatf("result_value got %0d want %0d",
						got_value, want.result_value));
				if (got_flag !== want.divisible_flag)
					report_mismatch($sformatf("divisible_flag got %0b want %0b",
						got_flag, want.divisible_flag));
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_random_mix();
		test_back_to_back();
		test_drain_pauses();
		test_random_long();

		s_tvalid <= 1'b0;
		wait_results_drained();
		repeat (TAIL_WAIT) @(posedge clk);
		if (pending_outcomes.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));

		if (mismatch_count == 0) begin
			$display("[integer_pair_gcd_unit_core] OK");
		end else begin
			$display("[integer_pair_gcd_unit_core] ERROR");
		end
		$finish;
	end

endmodule

// File: integer_pair_gcd_unit_core.f
sv/igcd_pkg.sv
sv/igcd_front.sv
sv/igcd_queue.sv
sv/igcd_back.sv
sv/integer_pair_gcd_unit_core.sv
sv/igcd_checker.sv
bench/tb_integer_pair_gcd_unit_core.sv
